[design/fdc_pkg.sv]
`default_nettype none
package fdc_pkg;

   localparam int BUFFER_BYTES_DEF = 1024;
   localparam int DRIVE_COUNT_DEF = 4;
   localparam int BUSY_POLLS_DEF = 64;
   localparam int SPINUP_MS_DEF = 1000;

   localparam int GEO_W = 39;
   localparam int CSR_IDX_W = 3;

   localparam logic [3:0] OP_CMD = 4'd0;
   localparam logic [3:0] OP_WR_TRACK = 4'd1;
   localparam logic [3:0] OP_WR_SECTOR = 4'd2;
   localparam logic [3:0] OP_WR_DATA = 4'd3;
   localparam logic [3:0] OP_RD_DATA = 4'd4;
   localparam logic [3:0] OP_STATUS = 4'd5;
   localparam logic [3:0] OP_STATUS_NC = 4'd6;
   localparam logic [3:0] OP_RD_TRACK = 4'd7;
   localparam logic [3:0] OP_RD_SECTOR = 4'd8;
   localparam logic [3:0] OP_DRIVE = 4'd9;
   localparam logic [3:0] OP_SIDE = 4'd10;
   localparam logic [3:0] OP_TICK = 4'd11;
   localparam logic [3:0] OP_MOTOR = 4'd12;
   localparam logic [3:0] OP_FILL = 4'd13;
   localparam logic [3:0] OP_PEEK = 4'd14;

   localparam logic [2:0] CSR_CTYPE = 3'd0;
   localparam logic [2:0] CSR_DENSITY = 3'd1;
   localparam logic [2:0] CSR_MOTOR_TO = 3'd2;
   localparam logic [2:0] CSR_GEO0 = 3'd3;
   localparam logic [2:0] CSR_GEO3 = 3'd6;

   localparam logic [3:0] CMD_RESTORE = 4'h0;
   localparam logic [3:0] CMD_SEEK = 4'h1;
   localparam logic [3:0] CMD_STEP = 4'h2;
   localparam logic [3:0] CMD_STEP_T = 4'h3;
   localparam logic [3:0] CMD_STEP_IN = 4'h4;
   localparam logic [3:0] CMD_STEP_IN_T = 4'h5;
   localparam logic [3:0] CMD_STEP_OUT = 4'h6;
   localparam logic [3:0] CMD_STEP_OUT_T = 4'h7;
   localparam logic [3:0] CMD_RD_SEC = 4'h8;
   localparam logic [3:0] CMD_WR_SEC = 4'hA;
   localparam logic [3:0] CMD_RD_ADDR = 4'hC;
   localparam logic [3:0] CMD_FORCE_INT = 4'hD;

   localparam logic [7:0] ST_NOTREADY = 8'h80;
   localparam logic [7:0] ST_HEADLOAD = 8'h20;
   localparam logic [7:0] ST_SEEKERR = 8'h10;
   localparam logic [7:0] ST_TRACK0 = 8'h04;
   localparam logic [7:0] ST_INDEX = 8'h02;
   localparam logic [7:0] ST_DRQ = 8'h02;
   localparam logic [7:0] ST_BUSY = 8'h01;

   localparam logic [1:0] CT_1772 = 2'd0;
   localparam logic [1:0] CT_179X_SIDE = 2'd2;

   localparam logic [1:0] DOP_NONE = 2'd0;
   localparam logic [1:0] DOP_FETCH = 2'd1;
   localparam logic [1:0] DOP_STORE = 2'd2;

   localparam logic [7:0] ID_MARK_A = 8'hFA;
   localparam logic [7:0] ID_MARK_B = 8'hAF;

   typedef struct packed {
      logic [3:0] opcode;
      logic [7:0] data_byte;
      logic [15:0] elapsed_ms;
      logic [9:0] buffer_index;
   } req_type;

   typedef struct packed {
      logic [7:0] read_value;
      logic interrupt_out;
      logic motor_running;
      logic [1:0] disk_op;
      logic [27:0] disk_offset;
      logic [10:0] disk_length;
   } rsp_type;

endpackage
`default_nettype wire

[design/fdc_buf.sv]
`default_nettype none
module fdc_buf #(
   parameter int BUFFER_BYTES = fdc_pkg::BUFFER_BYTES_DEF,
   localparam int AW = $clog2(BUFFER_BYTES)
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic wr_en,
   input wire logic [AW-1:0] wr_addr,
   input wire logic [7:0] wr_data,
   input wire logic rd_en,
   input wire logic [AW-1:0] rd_addr,
   output logic [7:0] rd_data,
   output logic clearing
);

   logic [7:0] mem [BUFFER_BYTES];
   logic clr_ff, clr_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   always_comb begin
      clr_in = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(BUFFER_BYTES - 1)) clr_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         clr_ff <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_cnt_ff] <= 8'h00;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) rd_data <= mem[rd_addr];
   end

   assign clearing = clr_ff;

endmodule
`default_nettype wire

[design/fdc_ctl.sv]
`default_nettype none
module fdc_ctl #(
   parameter int BUFFER_BYTES = fdc_pkg::BUFFER_BYTES_DEF,
   parameter int DRIVE_COUNT = fdc_pkg::DRIVE_COUNT_DEF,
   parameter int BUSY_POLLS = fdc_pkg::BUSY_POLLS_DEF,
   parameter int SPINUP_MS = fdc_pkg::SPINUP_MS_DEF,
   localparam int AW = $clog2(BUFFER_BYTES)
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic accept,
   input wire fdc_pkg::req_type req_data,
   input wire logic csr_we,
   input wire logic [fdc_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [fdc_pkg::GEO_W-1:0] csr_wdata,
   output logic mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output logic [7:0] mem_wr_data,
   output logic mem_rd_en,
   output logic [AW-1:0] mem_rd_addr,
   input wire logic [7:0] mem_rd_data,
   output logic active,
   output logic rsp_valid,
   output fdc_pkg::rsp_type rsp_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_MUL1 = 3'd2;
   localparam logic [2:0] S_MUL2 = 3'd3;
   localparam logic [2:0] S_MUL3 = 3'd4;
   localparam logic [2:0] S_ADDR = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   function automatic logic [AW-1:0] buf_mod(input logic [10:0] v);
      logic [15:0] r;
      r = {5'd0, v};
      for (int k = 4; k >= 0; k--) begin
         if (r >= 16'(BUFFER_BYTES << k)) r = r - 16'(BUFFER_BYTES << k);
      end
      return r[AW-1:0];
   endfunction

   function automatic logic [7:0] dens(input logic [7:0] st, input logic [1:0] hd,
                                       input logic [1:0] den);
      if (hd == 2'd0 || den == 2'd0 || hd == den) return st;
      return (st & (fdc_pkg::ST_TRACK0 | fdc_pkg::ST_HEADLOAD)) | fdc_pkg::ST_SEEKERR;
   endfunction

   logic [2:0] state_ff, state_in;
   fdc_pkg::req_type req_ff;
   logic [1:0] ctype_ff, hden_ff;
   logic [15:0] mto_ff;
   logic [fdc_pkg::GEO_W-1:0] geo_ff [4];

   logic [7:0] track_ff, track_in, sector_ff, sector_in, status_ff, status_in;
   logic [7:0] lastcmd_ff, lastcmd_in;
   logic [2:0] drv_ff, drv_in;
   logic [1:0] side_ff, side_in, dir_ff, dir_in;
   logic ra_ff, ra_in, wa_ff, wa_in, irq_ff, irq_in;
   logic [10:0] pos_ff, pos_in, rl_ff, rl_in;
   logic [6:0] busyc_ff, busyc_in;
   logic [15:0] motor_ff, motor_in;
   logic [9:0] spin_ff, spin_in;
   logic [7:0] rv_ff, rv_in, b1_ff, b1_in;
   logic [1:0] kind_ff, kind_in;
   logic seq_in;
   logic [2:0] cnt_ff;
   logic [31:0] p1_ff, p2_ff;
   logic [27:0] off_ff;
   logic [10:0] len_ff;

   logic [fdc_pkg::GEO_W-1:0] g;
   logic g_present;
   logic [7:0] g_tracks, g_spt, g_first, g_side1;
   logic [1:0] g_code, g_sides, g_den;
   logic [31:0] trel;
   logic [10:0] rl_end, size;
   logic rd_eq, rd_lt;

   always_comb begin
      g = (drv_ff < 3'(DRIVE_COUNT)) ? geo_ff[drv_ff[1:0]] : '0;
      g_present = g[0];
      g_tracks = g[8:1];
      g_spt = g[16:9];
      g_code = g[18:17];
      g_sides = g[20:19];
      g_first = g[28:21];
      g_side1 = g[36:29];
      g_den = g[38:37];
      trel = (side_ff != 2'd0) ? ({24'd0, track_ff} - {24'd0, g_side1}) : {24'd0, track_ff};
      rl_end = rl_ff - 11'd1;
      rd_eq = (rl_ff != 11'd0) && (pos_ff == rl_end);
      rd_lt = (rl_ff == 11'd0) || (pos_ff < rl_end);
      size = 11'd128 << g_code;
   end

   always_comb begin
      mem_rd_en = accept;
      mem_rd_addr = '0;
      if (req_data.opcode == fdc_pkg::OP_PEEK) begin
         mem_rd_addr = buf_mod({1'b0, req_data.buffer_index});
      end else if (req_data.opcode == fdc_pkg::OP_RD_DATA && ra_ff) begin
         mem_rd_addr = (rd_eq || rd_lt) ? buf_mod(pos_ff) : buf_mod(rl_end);
      end
   end

   always_comb begin
      logic [7:0] v;
      logic hl, mot, mon, sec_bad;
      logic [7:0] m;
      logic [15:0] ms;
      v = req_ff.data_byte;
      m = mem_rd_data;
      ms = req_ff.elapsed_ms;
      hl = v[3];
      mot = !v[3];
      mon = 1'b0;
      sec_bad = (sector_ff < g_first) || ((sector_ff - g_first) >= g_spt);
      track_in = track_ff;
      sector_in = sector_ff;
      status_in = status_ff;
      lastcmd_in = lastcmd_ff;
      drv_in = drv_ff;
      side_in = side_ff;
      dir_in = dir_ff;
      ra_in = ra_ff;
      wa_in = wa_ff;
      irq_in = irq_ff;
      pos_in = pos_ff;
      rl_in = rl_ff;
      busyc_in = busyc_ff;
      motor_in = motor_ff;
      spin_in = spin_ff;
      rv_in = 8'h00;
      b1_in = b1_ff;
      kind_in = fdc_pkg::DOP_NONE;
      seq_in = 1'b0;
      mem_wr_en = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = v;
      if (state_ff == S_EXEC) begin
         case (req_ff.opcode)
            fdc_pkg::OP_CMD: begin
               if (drv_ff >= 3'(DRIVE_COUNT) || !g_present) begin
                  status_in = fdc_pkg::ST_NOTREADY;
               end else begin
                  lastcmd_in = v;
                  busyc_in = 7'd0;
                  if (v[7:4] == fdc_pkg::CMD_FORCE_INT) begin
                     ra_in = 1'b0;
                     wa_in = 1'b0;
                     pos_in = 11'd0;
                     if (status_ff[0]) status_in = status_ff & ~fdc_pkg::ST_BUSY;
                     else status_in = (track_ff == 8'd0) ? fdc_pkg::ST_TRACK0 : 8'h00;
                     if ((v & 8'h0B) != 8'h00) irq_in = 1'b1;
                     mon = 1'b1;
                  end else if (!status_ff[0]) begin
                     status_in = fdc_pkg::ST_BUSY;
                     busyc_in = 7'(BUSY_POLLS);
                     ra_in = 1'b0;
                     wa_in = 1'b0;
                     pos_in = 11'd0;
                     irq_in = 1'b0;
                     case (v[7:4])
                        fdc_pkg::CMD_RESTORE: begin
                           track_in = 8'd0;
                           status_in = status_in | fdc_pkg::ST_TRACK0 | fdc_pkg::ST_INDEX;
                           if (hl) status_in = status_in | fdc_pkg::ST_HEADLOAD;
                           dir_in = 2'd1;
                           mon = mot;
                           if (hl) begin
                              if (side_ff >= g_sides)
                                 status_in = status_in | fdc_pkg::ST_SEEKERR;
                              else status_in = dens(status_in, hden_ff, g_den);
                           end
                        end
                        fdc_pkg::CMD_SEEK: begin
                           if (track_ff < m) dir_in = 2'd1;
                           if (track_ff > m) dir_in = 2'd3;
                           track_in = m;
                           status_in = status_in | fdc_pkg::ST_INDEX;
                           if (m >= g_tracks) begin
                              status_in = status_in | fdc_pkg::ST_SEEKERR;
                              if (hl) status_in = status_in | fdc_pkg::ST_HEADLOAD;
                           end else begin
                              if (m == 8'd0) status_in = status_in | fdc_pkg::ST_TRACK0;
                              if (hl && side_ff >= g_sides) begin
                                 status_in = status_in | fdc_pkg::ST_SEEKERR;
                              end else begin
                                 if (hl) begin
                                    status_in = status_in | fdc_pkg::ST_HEADLOAD;
                                    status_in = dens(status_in, hden_ff, g_den);
                                 end
                                 mon = 1'b1;
                              end
                           end
                        end
                        fdc_pkg::CMD_STEP, fdc_pkg::CMD_STEP_T: begin
                           if (track_in != 8'd0 && dir_ff == 2'd3) track_in = track_in - 8'd1;
                           if (track_in < 8'd128 && dir_ff == 2'd1) track_in = track_in + 8'd1;
                           status_in = status_in | fdc_pkg::ST_INDEX;
                           if (track_in == 8'd0) status_in = status_in | fdc_pkg::ST_TRACK0;
                           if (hl) begin
                              if (side_ff >= g_sides) begin
                                 status_in = fdc_pkg::ST_SEEKERR;
                                 irq_in = 1'b1;
                              end else begin
                                 status_in = status_in | fdc_pkg::ST_HEADLOAD;
                                 status_in = dens(status_in, hden_ff, g_den);
                              end
                           end
                        end
                        fdc_pkg::CMD_STEP_IN, fdc_pkg::CMD_STEP_IN_T: begin
                           if (trel < 32'd128) track_in = track_ff + 8'd1;
                           status_in = status_in | fdc_pkg::ST_INDEX;
                           if (hl && side_ff >= g_sides) begin
                              status_in = status_in | fdc_pkg::ST_SEEKERR;
                           end else begin
                              if (hl) begin
                                 status_in = status_in | fdc_pkg::ST_HEADLOAD;
                                 status_in = dens(status_in, hden_ff, g_den);
                              end
                              dir_in = 2'd1;
                              mon = mot;
                           end
                        end
                        fdc_pkg::CMD_STEP_OUT, fdc_pkg::CMD_STEP_OUT_T: begin
                           if (track_ff != 8'd0) track_in = track_ff - 8'd1;
                           status_in = fdc_pkg::ST_INDEX;
                           if (track_in == 8'd0) status_in = status_in | fdc_pkg::ST_TRACK0;
                           if (hl && side_ff >= g_sides) begin
                              status_in = fdc_pkg::ST_SEEKERR;
                              irq_in = 1'b1;
                           end else begin
                              if (hl) begin
                                 status_in = status_in | fdc_pkg::ST_HEADLOAD;
                                 status_in = dens(status_in, hden_ff, g_den);
                              end
                              dir_in = 2'd3;
                              mon = mot;
                           end
                        end
                        fdc_pkg::CMD_RD_SEC, fdc_pkg::CMD_WR_SEC: begin
                           if (trel >= {24'd0, g_tracks} || sec_bad || side_ff >= g_sides) begin
                              status_in = status_in | fdc_pkg::ST_SEEKERR;
                              if (v[7:4] == fdc_pkg::CMD_RD_SEC)
                                 status_in = status_in | fdc_pkg::ST_INDEX;
                           end else begin
                              if (ctype_ff == fdc_pkg::CT_179X_SIDE) side_in = {1'b0, v[1]};
                              status_in = status_in | fdc_pkg::ST_DRQ;
                              busyc_in = 7'd0;
                              status_in = dens(status_in, hden_ff, g_den);
                              mon = mot;
                              if (v[7:4] == fdc_pkg::CMD_RD_SEC) begin
                                 kind_in = fdc_pkg::DOP_FETCH;
                                 ra_in = 1'b1;
                                 rl_in = size;
                              end else begin
                                 wa_in = 1'b1;
                              end
                           end
                        end
                        fdc_pkg::CMD_RD_ADDR: begin
                           if (ctype_ff == fdc_pkg::CT_179X_SIDE) side_in = {1'b0, v[1]};
                           if (side_in >= g_sides) begin
                              status_in = status_in | fdc_pkg::ST_SEEKERR;
                           end else begin
                              status_in = status_in | fdc_pkg::ST_DRQ;
                              ra_in = 1'b1;
                              rl_in = 11'd7;
                              seq_in = 1'b1;
                              b1_in = (track_ff >= g_tracks) ? g_tracks - 8'd1 : trel[7:0];
                              if (ctype_ff == fdc_pkg::CT_1772) pos_in = 11'd1;
                              sector_in = track_ff;
                              irq_in = 1'b1;
                              mon = 1'b1;
                              busyc_in = 7'(BUSY_POLLS);
                              status_in = dens(status_in, hden_ff, g_den);
                           end
                        end
                        default: begin
                           status_in = status_in & ~fdc_pkg::ST_DRQ;
                           ra_in = 1'b0;
                           wa_in = 1'b0;
                        end
                     endcase
                  end
               end
            end
            fdc_pkg::OP_WR_TRACK: track_in = v;
            fdc_pkg::OP_WR_SECTOR: sector_in = v;
            fdc_pkg::OP_WR_DATA: begin
               if (!wa_ff) begin
                  mem_wr_en = 1'b1;
               end else if (drv_ff < 3'(DRIVE_COUNT) && pos_ff < size) begin
                  mem_wr_en = 1'b1;
                  mem_wr_addr = buf_mod(pos_ff);
                  pos_in = pos_ff + 11'd1;
                  if (pos_in == size) begin
                     kind_in = fdc_pkg::DOP_STORE;
                     status_in = status_ff & ~(fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ);
                     wa_in = 1'b0;
                     irq_in = 1'b1;
                  end
               end
            end
            fdc_pkg::OP_RD_DATA: begin
               rv_in = m;
               if (ra_ff && rd_eq) begin
                  status_in = status_ff & ~(fdc_pkg::ST_DRQ | fdc_pkg::ST_BUSY);
                  irq_in = 1'b1;
                  ra_in = 1'b0;
               end else if (ra_ff && rd_lt) begin
                  pos_in = pos_ff + 11'd1;
               end
            end
            fdc_pkg::OP_STATUS, fdc_pkg::OP_STATUS_NC: begin
               if (req_ff.opcode == fdc_pkg::OP_STATUS) irq_in = 1'b0;
               if (busyc_ff != 7'd0) begin
                  busyc_in = busyc_ff - 7'd1;
                  if (busyc_in == 7'd0) begin
                     status_in = status_ff & ~fdc_pkg::ST_BUSY;
                     irq_in = 1'b1;
                  end
               end
               if (ctype_ff == fdc_pkg::CT_1772)
                  rv_in = status_in | ((motor_ff != 16'd0) ? 8'h80 : 8'h00);
               else
                  rv_in = status_in | ((motor_ff != 16'd0) ? 8'h00 : 8'h80);
            end
            fdc_pkg::OP_RD_TRACK: rv_in = track_ff;
            fdc_pkg::OP_RD_SECTOR: rv_in = sector_ff;
            fdc_pkg::OP_DRIVE: drv_in = (v < 8'(DRIVE_COUNT)) ? v[2:0] : 3'd4;
            fdc_pkg::OP_SIDE: side_in = v[1:0];
            fdc_pkg::OP_TICK: begin
               if (motor_ff != 16'd0) begin
                  motor_in = (motor_ff <= ms) ? 16'd0 : motor_ff - ms;
                  if (spin_ff != 10'd0 && {6'd0, spin_ff} <= ms) begin
                     spin_in = 10'd0;
                     if (lastcmd_ff < 8'h80) status_in = status_ff | fdc_pkg::ST_HEADLOAD;
                  end
               end
            end
            fdc_pkg::OP_MOTOR: mon = (v != 8'd0);
            fdc_pkg::OP_FILL: begin
               mem_wr_en = 1'b1;
               mem_wr_addr = buf_mod({1'b0, req_ff.buffer_index});
            end
            fdc_pkg::OP_PEEK: rv_in = m;
            default: ;
         endcase
         if (mon && motor_ff == 16'd0) begin
            motor_in = mto_ff;
            spin_in = 10'(SPINUP_MS);
         end
      end else if (state_ff == S_ADDR) begin
         mem_wr_en = 1'b1;
         mem_wr_addr = AW'(cnt_ff);
         case (cnt_ff)
            3'd0: mem_wr_data = 8'h00;
            3'd1: mem_wr_data = b1_ff;
            3'd2: mem_wr_data = {6'd0, side_ff};
            3'd3: mem_wr_data = g_first;
            3'd4: mem_wr_data = {6'd0, g_code};
            3'd5: mem_wr_data = fdc_pkg::ID_MARK_A;
            default: mem_wr_data = fdc_pkg::ID_MARK_B;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_EXEC;
         S_EXEC: begin
            if (kind_in != fdc_pkg::DOP_NONE) state_in = S_MUL1;
            else if (seq_in) state_in = S_ADDR;
            else state_in = S_DONE;
         end
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_MUL3;
         S_MUL3: state_in = S_DONE;
         S_ADDR: if (cnt_ff == 3'd6) state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ctype_ff <= 2'd1;
         hden_ff <= 2'd0;
         mto_ff <= 16'd10000;
         for (int i = 0; i < 4; i++) geo_ff[i] <= '0;
         track_ff <= '0;
         sector_ff <= '0;
         status_ff <= '0;
         lastcmd_ff <= '0;
         drv_ff <= '0;
         side_ff <= '0;
         dir_ff <= '0;
         ra_ff <= 1'b0;
         wa_ff <= 1'b0;
         irq_ff <= 1'b0;
         pos_ff <= '0;
         rl_ff <= '0;
         busyc_ff <= '0;
         motor_ff <= '0;
         spin_ff <= '0;
         kind_ff <= fdc_pkg::DOP_NONE;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            if (csr_index == fdc_pkg::CSR_CTYPE) ctype_ff <= csr_wdata[1:0];
            if (csr_index == fdc_pkg::CSR_DENSITY) hden_ff <= csr_wdata[1:0];
            if (csr_index == fdc_pkg::CSR_MOTOR_TO) mto_ff <= csr_wdata[15:0];
            if (csr_index >= fdc_pkg::CSR_GEO0 && csr_index <= fdc_pkg::CSR_GEO3)
               geo_ff[2'(csr_index - fdc_pkg::CSR_GEO0)] <= csr_wdata;
         end
         track_ff <= track_in;
         sector_ff <= sector_in;
         status_ff <= status_in;
         lastcmd_ff <= lastcmd_in;
         drv_ff <= drv_in;
         side_ff <= side_in;
         dir_ff <= dir_in;
         ra_ff <= ra_in;
         wa_ff <= wa_in;
         irq_ff <= irq_in;
         pos_ff <= pos_in;
         rl_ff <= rl_in;
         busyc_ff <= busyc_in;
         motor_ff <= motor_in;
         spin_ff <= spin_in;
         if (state_ff == S_EXEC) kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      if (state_ff == S_EXEC) begin
         rv_ff <= rv_in;
         b1_ff <= b1_in;
         cnt_ff <= 3'd0;
         off_ff <= '0;
         len_ff <= '0;
      end
      if (state_ff == S_ADDR) cnt_ff <= cnt_ff + 3'd1;
      if (state_ff == S_MUL1) p1_ff <= trel * {24'd0, g_spt};
      if (state_ff == S_MUL2)
         p2_ff <= p1_ff * {30'd0, g_sides} + ({24'd0, sector_ff} - {24'd0, g_first})
                  + ((g_sides == 2'd2 && side_ff != 2'd0) ? {24'd0, g_spt} : 32'd0);
      if (state_ff == S_MUL3) begin
         off_ff <= 28'(p2_ff << (7 + int'(g_code)));
         len_ff <= size;
      end
   end

   assign active = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   always_comb begin
      rsp_data.read_value = rv_ff;
      rsp_data.interrupt_out = irq_ff;
      rsp_data.motor_running = (motor_ff != 16'd0);
      rsp_data.disk_op = kind_ff;
      rsp_data.disk_offset = off_ff;
      rsp_data.disk_length = len_ff;
   end

endmodule
`default_nettype wire

[design/floppy_disk_controller_registers_core.sv]
`default_nettype none
// Channel   Ports                                  Transfer
// request   start, busy, req_data                  start && !busy
// response  rsp_valid, rsp_data                    rsp_valid, one cycle
// config    csr_we, csr_index, csr_wdata           csr_we
//
// A transaction goes through the EXEC and DONE states; sector fetch or store
// requests add MUL1 to MUL3 (two registered multiplies and a shift for the
// offset); read address adds ADDR, writing the seven ID bytes through the
// single buffer write port. After reset the sector buffer is cleared, busy high.
// Reset is synchronous, active high. Responses cannot be stalled.
module floppy_disk_controller_registers_core #(
   parameter int BUFFER_BYTES = fdc_pkg::BUFFER_BYTES_DEF,
   parameter int DRIVE_COUNT = fdc_pkg::DRIVE_COUNT_DEF,
   parameter int BUSY_POLLS = fdc_pkg::BUSY_POLLS_DEF,
   parameter int SPINUP_MS = fdc_pkg::SPINUP_MS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire fdc_pkg::req_type req_data,
   output logic rsp_valid,
   output fdc_pkg::rsp_type rsp_data,
   input wire logic csr_we,
   input wire logic [fdc_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [fdc_pkg::GEO_W-1:0] csr_wdata
);

   localparam int AW = $clog2(BUFFER_BYTES);

   logic wr_en, rd_en, clearing, active, accept;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0] wr_data, rd_data;

   assign busy = active || clearing;
   assign accept = start && !busy;

   fdc_buf #(.BUFFER_BYTES(BUFFER_BYTES)) u_buf (
      .clock(clock),
      .reset(reset),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .clearing(clearing)
   );

   fdc_ctl #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .DRIVE_COUNT(DRIVE_COUNT),
      .BUSY_POLLS(BUSY_POLLS),
      .SPINUP_MS(SPINUP_MS)
   ) u_ctl (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req_data(req_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mem_wr_en(wr_en),
      .mem_wr_addr(wr_addr),
      .mem_wr_data(wr_data),
      .mem_rd_en(rd_en),
      .mem_rd_addr(rd_addr),
      .mem_rd_data(rd_data),
      .active(active),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire
